@@ hw/rtl/mild_pkg.sv @@
// ----------------------------------------------------------------------------
// mild_pkg: shared types and constants of the motion inactivity lost detector
// Holds the item and result payload types, the configuration bundle, the
// tracking state type, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package mild_pkg;

  // Default report interval in seconds.
  localparam int unsigned REPORT_EVERY = 10;

  // Number of axes carried by one sample, and the width of one axis.
  localparam int unsigned AXES   = 3;
  localparam int unsigned AXIS_W = 16;

  // Width of the report-interval residue (the interval is at most 255).
  localparam int unsigned RES_W = 8;

  // Register reset values.
  localparam logic [15:0] DEAD_BAND_RST    = 16'd5000;
  localparam logic [15:0] LOST_AFTER_RST   = 16'd60;
  localparam logic [7:0]  TICK_SECONDS_RST = 8'd10;

  // Register indexes (word index within the register window).
  localparam logic [1:0] REG_DEAD_BAND    = 2'd0;
  localparam logic [1:0] REG_LOST_AFTER   = 2'd1;
  localparam logic [1:0] REG_TICK_SECONDS = 2'd2;

  // Item commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic {
    ST_FOUND,
    ST_LOST
  } track_state_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } item_t;

  typedef struct packed {
    logic        is_lost;
    logic        motion_seen;
    logic        became_lost;
    logic        became_found;
    logic        report_valid;
    logic [15:0] report_seconds;
  } result_t;

  // Configuration as seen by the tracker.
  typedef struct packed {
    logic [15:0]      lost_after;
    logic [7:0]       tick_seconds;
    logic [RES_W-1:0] tick_mod;
  } track_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/mild_axis_lane.sv @@
// ----------------------------------------------------------------------------
// mild_axis_lane: motion test for one accelerometer axis
// Keeps the previous sample of its axis and flags when the new sample differs
// from it by more than the dead band, taking the difference at full width.
// ----------------------------------------------------------------------------
`default_nettype none

module mild_axis_lane (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [mild_pkg::AXIS_W-1:0] sample,
  input  wire logic [15:0]                 dead_band,
  output logic                             moved
);

  logic [mild_pkg::AXIS_W-1:0] last;
  logic signed [mild_pkg::AXIS_W:0] diff;
  logic [mild_pkg::AXIS_W:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= '0;
    end else if (load) begin
      last <= sample;
    end
  end

  // A 17-bit difference cannot overflow; its magnitude fits 17 bits unsigned.
  always_comb begin
    diff  = $signed({sample[mild_pkg::AXIS_W-1], sample})
          - $signed({last[mild_pkg::AXIS_W-1], last});
    mag   = diff[mild_pkg::AXIS_W] ? (~diff + 1'b1) : diff;
    moved = mag > {1'b0, dead_band};
  end

endmodule

`default_nettype wire

@@ hw/rtl/mild_tracker.sv @@
// ----------------------------------------------------------------------------
// mild_tracker: lane merge and found/lost tracking
// Combines the lane flags, runs the stillness counter and report arming on
// ticks, and the found/lost state machine on samples.
// ----------------------------------------------------------------------------
`default_nettype none

module mild_tracker #(
  parameter int unsigned ReportEvery = mild_pkg::REPORT_EVERY
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic                       command,
  input  wire logic [mild_pkg::AXES-1:0]  lane_moved,
  input  wire mild_pkg::track_cfg_t       cfg,
  output mild_pkg::result_t               result
);

  localparam logic [mild_pkg::RES_W:0]   REP_N   = (mild_pkg::RES_W + 1)'(ReportEvery);
  localparam logic [mild_pkg::RES_W-1:0] SAT_MOD = mild_pkg::RES_W'(32'd65535 % ReportEvery);

  mild_pkg::track_state_t state, state_next;
  logic [15:0]               count, count_next;
  logic [mild_pkg::RES_W-1:0] residue, residue_next;
  logic                      armed, armed_next;

  logic [16:0]               sum;
  logic [mild_pkg::RES_W:0]  res_sum;
  logic                      moved;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mild_pkg::ST_FOUND;
      count   <= '0;
      residue <= '0;
      armed   <= 1'b0;
    end else if (accept) begin
      state   <= state_next;
      count   <= count_next;
      residue <= residue_next;
      armed   <= armed_next;
    end
  end

  always_comb begin
    moved        = |lane_moved;
    state_next   = state;
    count_next   = count;
    residue_next = residue;
    armed_next   = armed;
    result       = '0;
    sum          = {1'b0, count} + {9'd0, cfg.tick_seconds};
    res_sum      = {1'b0, residue} + {1'b0, cfg.tick_mod};

    if (command == mild_pkg::CMD_TICK) begin
      // Saturating add, with the residue modulo the report interval alongside.
      if (sum[16]) begin
        count_next   = 16'hFFFF;
        residue_next = SAT_MOD;
      end else begin
        count_next   = sum[15:0];
        residue_next = (res_sum >= REP_N) ? mild_pkg::RES_W'(res_sum - REP_N)
                                          : res_sum[mild_pkg::RES_W-1:0];
      end
      if ((count_next >= cfg.lost_after) && (residue_next == '0)) begin
        armed_next = 1'b1;
      end
    end else begin
      result.motion_seen = moved;
      unique case (state)
        mild_pkg::ST_FOUND: begin
          if (moved) begin
            count_next   = '0;
            residue_next = '0;
          end else if (count >= cfg.lost_after) begin
            state_next         = mild_pkg::ST_LOST;
            result.became_lost = 1'b1;
          end
        end
        mild_pkg::ST_LOST: begin
          if (armed) begin
            result.report_valid   = 1'b1;
            result.report_seconds = (count >= cfg.lost_after) ? count - cfg.lost_after
                                                              : 16'd0;
            armed_next            = 1'b0;
          end
          if (moved) begin
            count_next          = '0;
            residue_next        = '0;
            armed_next          = 1'b0;
            state_next          = mild_pkg::ST_FOUND;
            result.became_found = 1'b1;
          end
        end
        default: begin
          state_next = mild_pkg::ST_FOUND;
        end
      endcase
    end
    result.is_lost = (state_next == mild_pkg::ST_LOST);
  end

endmodule

`default_nettype wire

@@ hw/rtl/mild_out_buf.sv @@
// ----------------------------------------------------------------------------
// mild_out_buf: result register with skid stage
// Holds finished results so that input acceptance never waits on the
// consumer for more than one stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module mild_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire mild_pkg::result_t push_data,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mild_pkg::result_t      out_data
);

  mild_pkg::result_t skid;
  logic              skid_valid;
  logic              pop;

  assign room = !skid_valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/motion_inactivity_lost_detector.sv @@
// ----------------------------------------------------------------------------
// motion_inactivity_lost_detector: accelerometer motion and lost-time tracker
// Takes accelerometer samples and timer ticks, flags motion, tracks the
// found/lost state and reports time spent lost at each report interval.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                     Payload
//  --------  ----------------------------  ----------------------------------
//  item      item_valid / item_ready       item   (mild_pkg::item_t)
//  result    result_valid / result_ready   result (mild_pkg::result_t)
//  config    psel / penable / pready       paddr, pwdata, prdata (APB style)
//
// Every item produces exactly one result. An item is worked out in the cycle
// it is accepted and its result appears in the output register on the next
// cycle while results are taken, so one item per cycle is sustained; the only
// limit is the two-entry result buffer. Reset (rst, synchronous) returns the
// state to found with the counter, arming and previous samples cleared, and
// the registers to their defaults. While the consumer stalls, one further item
// still enters the skid stage; item_ready then drops until the stall clears.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_inactivity_lost_detector #(
  parameter int unsigned ReportEvery = mild_pkg::REPORT_EVERY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // Item channel.
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire mild_pkg::item_t   item,
  // Result channel.
  output logic                   result_valid,
  input  wire logic              result_ready,
  output mild_pkg::result_t      result,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  // Residue of each possible tick step modulo the report interval, built at
  // elaboration so that a tick step write only needs a table lookup.
  typedef logic [mild_pkg::RES_W-1:0] mod_tab_t [256];

  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = mild_pkg::RES_W'(i % ReportEvery);
    end
    return tab;
  endfunction

  localparam mod_tab_t TICK_MOD = build_mod_tab();

  logic [15:0]                dead_band;
  logic [15:0]                lost_after;
  logic [7:0]                 tick_seconds;
  logic [mild_pkg::RES_W-1:0] tick_mod;

  logic                       cfg_write;
  logic [1:0]                 reg_index;
  logic                       accept;
  logic                       lane_load;
  logic [mild_pkg::AXES-1:0]  lane_moved;
  logic [mild_pkg::AXES-1:0][mild_pkg::AXIS_W-1:0] axis_now;
  mild_pkg::track_cfg_t       track_cfg;
  mild_pkg::result_t          track_result;

  // Configuration registers. The register window is word addressed; writes
  // to the unused fourth word are dropped.
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band    <= mild_pkg::DEAD_BAND_RST;
      lost_after   <= mild_pkg::LOST_AFTER_RST;
      tick_seconds <= mild_pkg::TICK_SECONDS_RST;
      tick_mod     <= TICK_MOD[mild_pkg::TICK_SECONDS_RST];
    end else if (cfg_write) begin
      unique case (reg_index)
        mild_pkg::REG_DEAD_BAND:  dead_band  <= pwdata[15:0];
        mild_pkg::REG_LOST_AFTER: lost_after <= pwdata[15:0];
        mild_pkg::REG_TICK_SECONDS: begin
          tick_seconds <= pwdata[7:0];
          tick_mod     <= TICK_MOD[pwdata[7:0]];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      mild_pkg::REG_DEAD_BAND:    prdata = {16'd0, dead_band};
      mild_pkg::REG_LOST_AFTER:   prdata = {16'd0, lost_after};
      mild_pkg::REG_TICK_SECONDS: prdata = {24'd0, tick_seconds};
      default:                    prdata = 32'd0;
    endcase
  end

  // An item is taken whenever the result buffer has a free slot.
  assign accept    = item_valid && item_ready;
  assign lane_load = accept && (item.command == mild_pkg::CMD_SAMPLE);
  assign axis_now  = {item.accel_z, item.accel_y, item.accel_x};

  // One lane per axis, each holding its previous sample.
  for (genvar a = 0; a < mild_pkg::AXES; a++) begin : g_lane
    mild_axis_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .load      (lane_load),
      .sample    (axis_now[a]),
      .dead_band (dead_band),
      .moved     (lane_moved[a])
    );
  end

  assign track_cfg = '{lost_after:   lost_after,
                       tick_seconds: tick_seconds,
                       tick_mod:     tick_mod};

  // Merge of the lane flags and the found/lost state machine.
  mild_tracker #(
    .ReportEvery (ReportEvery)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (item.command),
    .lane_moved (lane_moved),
    .cfg        (track_cfg),
    .result     (track_result)
  );

  // Output register and skid stage.
  mild_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (track_result),
    .room      (item_ready),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_data  (result)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mild_checker.sv @@
// ----------------------------------------------------------------------------
// mild_checker: port-level checks of the motion inactivity lost detector
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

module mild_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire mild_pkg::result_t result
);

  // A stalled result stays offered and unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or was withdrawn");

  // The buffer is empty after reset, so an item can be taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> item_ready)
    else $error("item_ready low straight after reset");

  // Report seconds are zero without a report; a report only comes from the
  // lost state, which is left only on motion.
  a_report: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.report_valid || result.report_seconds == 16'd0) &&
                     (!result.report_valid || result.is_lost || result.motion_seen))
    else $error("inconsistent report fields");

  // State change pulses agree with the state after the item.
  a_transitions: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.became_lost && result.became_found) &&
                     (!result.became_lost || (result.is_lost && !result.motion_seen)) &&
                     (!result.became_found || (!result.is_lost && result.motion_seen)))
    else $error("state change pulse disagrees with state");

endmodule

bind motion_inactivity_lost_detector mild_checker u_mild_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

@@ test/mild_checker.sv @@
// ----------------------------------------------------------------------------
// mild_scoreboard: result predictor and scoreboard for the lost detector
// Watches the item, result and configuration channels, predicts each result
// from its own copy of the tracking state and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mild_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  mild_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  mild_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       mismatch_count,
  output int unsigned       outcomes_due
);

  logic [15:0] band_q;
  logic [15:0] limit_q;
  logic [7:0]  tick_secs_q;

  mild_pkg::track_state_t trk_state;
  logic [15:0]            still_secs;
  logic                   armed;
  logic signed [15:0]     prev_x;
  logic signed [15:0]     prev_y;
  logic signed [15:0]     prev_z;

  mild_pkg::result_t tracker_outcomes[$];
  mild_pkg::result_t want;
  mild_pkg::result_t fresh;

  initial begin
    mismatch_count = 0;
    outcomes_due   = 0;
  end

  // The difference is taken at 17 bits so that opposite extremes do not wrap.
  function automatic logic axis_moved(logic signed [15:0] now_v,
                                      logic signed [15:0] then_v,
                                      logic [15:0] band);
    logic signed [16:0] diff;
    logic [16:0]        mag;
    diff = {now_v[15], now_v} - {then_v[15], then_v};
    mag  = diff[16] ? 17'(-diff) : 17'(diff);
    return mag > {1'b0, band};
  endfunction

  task automatic track_item(input mild_pkg::item_t it, output mild_pkg::result_t res);
    logic [16:0] sum;
    logic        moved;
    res   = '0;
    moved = 1'b0;
    if (it.command == mild_pkg::CMD_TICK) begin
      sum        = {1'b0, still_secs} + {9'd0, tick_secs_q};
      still_secs = sum[16] ? 16'hFFFF : sum[15:0];
      if (still_secs >= limit_q && (still_secs % mild_pkg::REPORT_EVERY) == 0)
        armed = 1'b1;
    end else begin
      moved = axis_moved(it.accel_x, prev_x, band_q) |
              axis_moved(it.accel_y, prev_y, band_q) |
              axis_moved(it.accel_z, prev_z, band_q);
      prev_x = it.accel_x;
      prev_y = it.accel_y;
      prev_z = it.accel_z;
      if (trk_state == mild_pkg::ST_FOUND) begin
        if (moved) begin
          still_secs = '0;
        end else if (still_secs >= limit_q) begin
          trk_state       = mild_pkg::ST_LOST;
          res.became_lost = 1'b1;
        end
      end else begin
        if (armed) begin
          res.report_valid   = 1'b1;
          res.report_seconds = (still_secs >= limit_q) ? still_secs - limit_q : '0;
          armed              = 1'b0;
        end
        if (moved) begin
          still_secs       = '0;
          armed            = 1'b0;
          trk_state        = mild_pkg::ST_FOUND;
          res.became_found = 1'b1;
        end
      end
    end
    res.is_lost     = (trk_state == mild_pkg::ST_LOST);
    res.motion_seen = moved;
  endtask

  task automatic check_field(input string fname, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      band_q      = mild_pkg::DEAD_BAND_RST;
      limit_q     = mild_pkg::LOST_AFTER_RST;
      tick_secs_q = mild_pkg::TICK_SECONDS_RST;
      trk_state   = mild_pkg::ST_FOUND;
      still_secs  = '0;
      armed       = 1'b0;
      prev_x      = '0;
      prev_y      = '0;
      prev_z      = '0;
      tracker_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          mild_pkg::REG_DEAD_BAND:    band_q      = pwdata[15:0];
          mild_pkg::REG_LOST_AFTER:   limit_q     = pwdata[15:0];
          mild_pkg::REG_TICK_SECONDS: tick_secs_q = pwdata[7:0];
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (tracker_outcomes.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none due, expected nothing, actual %h",
                   $time, result);
        end else begin
          want = tracker_outcomes.pop_front();
          check_field("is_lost", 32'(want.is_lost), 32'(result.is_lost));
          check_field("motion_seen", 32'(want.motion_seen), 32'(result.motion_seen));
          check_field("became_lost", 32'(want.became_lost), 32'(result.became_lost));
          check_field("became_found", 32'(want.became_found),
                      32'(result.became_found));
          check_field("report_valid", 32'(want.report_valid),
                      32'(result.report_valid));
          check_field("report_seconds", 32'(want.report_seconds),
                      32'(result.report_seconds));
        end
      end
      if (item_valid && item_ready) begin
        track_item(item, fresh);
        tracker_outcomes.push_back(fresh);
      end
    end
    outcomes_due = tracker_outcomes.size();
  end

endmodule

@@ test/tb_motion_inactivity_lost_detector.sv @@
// ----------------------------------------------------------------------------
// tb_motion_inactivity_lost_detector: stimulus and verdict for the detector
// Drives samples and ticks through a series of register settings, with
// random idling on both channels, and leaves prediction to mild_scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_motion_inactivity_lost_detector;

  // Index past the last register; a write there must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Length of the deliberate receiver hold-off, in clock cycles. It is far
  // longer than the block's buffering, so item_ready has to drop.
  localparam int unsigned LONG_HOLD = 200;

  // Generous upper bound on the run; the slowest correct run is well under
  // a tenth of this.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  mild_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  mild_pkg::result_t result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned mismatch_count;
  int unsigned outcomes_due;

  // Idling controls. Both are switched off for the closing part of the run.
  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  // Set by the stimulus process to ask the receiver for one long hold-off.
  bit long_hold_req = 1'b0;

  // The sender's own note of the last sample, so that random samples can
  // be placed just inside or just outside the dead band.
  logic signed [15:0] stim_x = '0;
  logic signed [15:0] stim_y = '0;
  logic signed [15:0] stim_z = '0;
  int unsigned        cur_band = 32'(mild_pkg::DEAD_BAND_RST);
  int unsigned        tick_run = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  motion_inactivity_lost_detector DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mild_scoreboard u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .outcomes_due   (outcomes_due)
  );

  // A sample item with the three axes given.
  function automatic mild_pkg::item_t sample_of(logic signed [15:0] x,
                                                logic signed [15:0] y,
                                                logic signed [15:0] z);
    mild_pkg::item_t s;
    s.command = mild_pkg::CMD_SAMPLE;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    return s;
  endfunction

  // A tick item. The axis fields are ignored by the block, so they carry
  // random values to exercise every bit of them.
  function automatic mild_pkg::item_t tick_of();
    mild_pkg::item_t t;
    t.command = mild_pkg::CMD_TICK;
    t.accel_x = 16'($urandom);
    t.accel_y = 16'($urandom);
    t.accel_z = 16'($urandom);
    return t;
  endfunction

  // Moves one axis away from its last value, either within the dead band or
  // just beyond it. Clamping at the rails can only shrink the step.
  function automatic logic signed [15:0] nudge_axis(logic signed [15:0] from,
                                                    int unsigned band, bit push_out);
    int step;
    int v;
    step = push_out ? int'(band) + 1 + int'($urandom_range(0, 64))
                    : int'($urandom_range(0, band));
    v = ($urandom_range(0, 1) == 1) ? int'(from) + step : int'(from) - step;
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Offers one item and returns at the rising edge at which it is taken.
  // An idle burst, when one is drawn, falls before the item is raised, so
  // valid is only ever lowered and raised at different falling edges.
  task automatic send_item(input mild_pkg::item_t it);
    @(negedge clk);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    item_valid = 1'b1;
    item       = it;
    if (it.command == mild_pkg::CMD_SAMPLE) begin
      stim_x = it.accel_x;
      stim_y = it.accel_y;
      stim_z = it.accel_z;
    end
    do @(posedge clk); while (!item_ready);
  endtask

  // Draws the next random item. Most samples sit inside the dead band so
  // that the counter can climb to the limit; runs of ticks push it there
  // quickly, and a minority of samples move or are fully random.
  task automatic pick_random_item(output mild_pkg::item_t it);
    int unsigned roll;
    int unsigned hot;
    roll = $urandom_range(0, 99);
    if (tick_run == 0 && roll < 8) tick_run = $urandom_range(3, 25);
    if (tick_run > 0) begin
      tick_run--;
      it = tick_of();
    end else if (roll < 45) begin
      it = tick_of();
    end else if (roll < 88) begin
      it = sample_of(nudge_axis(stim_x, cur_band, 1'b0),
                     nudge_axis(stim_y, cur_band, 1'b0),
                     nudge_axis(stim_z, cur_band, 1'b0));
    end else if (roll < 95) begin
      hot = $urandom_range(0, 2);
      it = sample_of(nudge_axis(stim_x, cur_band, hot == 0),
                     nudge_axis(stim_y, cur_band, hot == 1),
                     nudge_axis(stim_z, cur_band, hot == 2));
    end else begin
      it = sample_of(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_random(input int unsigned count);
    mild_pkg::item_t it;
    repeat (count) begin
      pick_random_item(it);
      send_item(it);
    end
  endtask

  // One register write: a setup phase, then an access phase held until
  // pready is seen at a rising edge.
  task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {index, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input int unsigned band, input int unsigned limit,
                            input int unsigned secs);
    apb_write(mild_pkg::REG_DEAD_BAND, band);
    apb_write(mild_pkg::REG_LOST_AFTER, limit);
    apb_write(mild_pkg::REG_TICK_SECONDS, secs);
    cur_band = band;
  endtask

  // Waits until every item sent so far has produced its result. Every item
  // yields a result, so nothing is left in flight after. The falling edge
  // first lets the scoreboard take in the last accepted item.
  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    wait (outcomes_due == 0);
    repeat (3) @(posedge clk);
  endtask

  // Receiver. Each falling edge either continues a stall, starts the long
  // hold-off on request, draws a short random stall, or accepts.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        result_ready  = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        hold_left    = $urandom_range(0, 9);
        result_ready = 1'b0;
      end else begin
        result_ready = 1'b1;
      end
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned k;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: dead band 5000, limit 60, ten seconds per tick.
    // Opposite axis extremes, then a full-width jump the other way.
    send_item(sample_of(16'sd32767, -16'sd32768, 16'sd0));
    send_item(sample_of(-16'sd32768, 16'sd32767, 16'sd0));
    send_item(sample_of(-16'sd32768, 16'sd32767, 16'sd0));
    // A change of exactly the dead band is still; one more counts as motion.
    send_item(sample_of(-16'sd27768, 16'sd32767, 16'sd0));
    send_item(sample_of(-16'sd22767, 16'sd32767, 16'sd0));
    // Six ticks reach the limit and arm a report while still found.
    for (k = 0; k < 6; k++) send_item(tick_of());
    // A still sample enters the lost state; the armed report waits for the
    // next sample, which then reports zero seconds beyond the limit.
    send_item(sample_of(-16'sd22767, 16'sd32767, -16'sd5000));
    send_item(sample_of(-16'sd22767, 16'sd32767, -16'sd5000));
    // Rearm, then move while lost: the report comes out in the same result as
    // the return to found.
    send_item(tick_of());
    send_item(sample_of(-16'sd22767, 16'sd27766, -16'sd5000));
    send_item(tick_of());
    send_item(sample_of(-16'sd22767, 16'sd27766, -16'sd5000));
    send_random(60);
    settle();

    // Lowest settings: any change is motion and any stillness means lost.
    set_config(0, 0, 1);
    send_random(80);
    settle();

    // Highest settings: no change can exceed the band, and the counter has
    // to reach its top value before the lost state is reached.
    set_config(65535, 65535, 255);
    for (k = 0; k < 260; k++) send_item(tick_of());
    send_random(40);
    settle();

    // Raising the limit while lost: the next report saturates at zero.
    set_config(5000, 20, 10);
    send_item(sample_of(-16'sd32768, -16'sd32768, -16'sd32768));
    send_item(sample_of(16'sd32767, 16'sd32767, 16'sd32767));
    send_item(tick_of());
    send_item(tick_of());
    send_item(sample_of(16'sd32767, 16'sd32767, 16'sd32767));
    send_item(tick_of());
    settle();
    apb_write(mild_pkg::REG_LOST_AFTER, 1000);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    send_item(sample_of(16'sd32767, 16'sd32767, 16'sd32767));
    settle();

    // Typical settings, opened by a long receiver hold-off while the sender
    // keeps offering, so that the block fills and stalls its input.
    set_config($urandom_range(1000, 9000), $urandom_range(0, 120), $urandom_range(1, 30));
    long_hold_req = 1'b1;
    send_random(100);
    settle();

    // Tight band with a long limit and large ticks.
    set_config($urandom_range(0, 200), $urandom_range(100, 400), $urandom_range(20, 60));
    send_random(100);
    settle();

    // Dead band across its whole range, limit up to 300, any nonzero tick step.
    set_config($urandom_range(0, 65535), $urandom_range(0, 300), $urandom_range(1, 255));
    send_random(100);
    settle();

    // Closing part without idling on either side.
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    set_config($urandom_range(2000, 6000), $urandom_range(0, 80), $urandom_range(1, 20));
    send_random(90);
    settle();

    if (mismatch_count == 0 && outcomes_due == 0) begin
      $display("motion_inactivity_lost_detector test passed");
    end else begin
      $display("motion_inactivity_lost_detector test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("motion_inactivity_lost_detector test failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mild_pkg.sv
hw/rtl/mild_axis_lane.sv
hw/rtl/mild_tracker.sv
hw/rtl/mild_out_buf.sv
hw/rtl/motion_inactivity_lost_detector.sv
hw/rtl/mild_checker.sv
test/mild_checker.sv
test/tb_motion_inactivity_lost_detector.sv
